>>> hdl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the nearest-voxel address pipeline.
// ----------------------------------------------------------------------------
package vna_pkg;

  // configuration port
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 6;

  // word fields
  localparam int unsigned COORD_W = 32;
  localparam int unsigned IDX_W   = 30;

  // packed resolution register
  localparam int unsigned GRID_W    = 33;
  localparam int unsigned RES_FLD_W = 11;
  localparam int unsigned RES_X_LSB = 0;
  localparam int unsigned RES_Y_LSB = 11;
  localparam int unsigned RES_Z_LSB = 22;
  localparam int unsigned MIN_RES   = 2;

  // remainder bits resolved per pipeline stage
  localparam int unsigned DIV_STEP = 4;

  // register reset values
  localparam logic [COORD_W-1:0] SCALE_RST  = 32'd65536;
  localparam logic [COORD_W-1:0] OFFSET_RST = 32'd0;
  localparam logic [GRID_W-1:0]  GRID_RST   = 33'd2151680;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_SCALE_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_GRID_RES = 3'd6
  } reg_idx_e;

endpackage

>>> hdl/vna_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// vna_pipe_ctrl
// Valid bits and per-stage load enables; bubbles are squeezed out on stall.
// ----------------------------------------------------------------------------
module vna_pipe_ctrl #(
  parameter int unsigned N_STG = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_stall_i,
  output logic             in_stall_o,
  output logic [N_STG-1:0] ld_o,
  output logic [N_STG-1:0] valid_o
);

  logic [N_STG-1:0] valid_q, valid_d;
  logic [N_STG:0]   ready;

  always_comb begin
    ready[N_STG] = ~out_stall_i;
    for (int k = N_STG - 1; k >= 0; k--) begin
      ready[k] = ~valid_q[k] | ready[k+1];
    end
  end

  always_comb begin
    ld_o[0] = in_valid_i & ready[0];
    for (int k = 1; k < N_STG; k++) begin
      ld_o[k] = valid_q[k-1] & ready[k];
    end
    for (int k = 0; k < N_STG; k++) begin
      valid_d[k] = ld_o[k] | (valid_q[k] & ~ready[k+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = ~ready[0];
  assign valid_o    = valid_q;

  // input only backs up when every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted word lost at first stage");

endmodule

>>> hdl/vna_grid_map.sv
// ----------------------------------------------------------------------------
// vna_grid_map
// One axis into grid space: product, floor shift, offset add, saturation.
// ----------------------------------------------------------------------------
module vna_grid_map #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic [1:0]                          ld_i,
  input  logic signed [vna_pkg::COORD_W-1:0]  point_i,
  input  logic signed [vna_pkg::COORD_W-1:0]  scale_i,
  input  logic signed [vna_pkg::COORD_W-1:0]  offset_i,
  output logic signed [vna_pkg::COORD_W-1:0]  grid_o
);

  localparam int unsigned CW = vna_pkg::COORD_W;
  localparam int unsigned PW = 2 * CW;
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] shr;
  logic                 ovf_mul;
  logic        [CW-1:0] trunc;
  logic        [CW:0]   sum;
  logic        [CW-1:0] grid_d, grid_q;

  assign prod_d = point_i * scale_i;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign shr     = prod_q >>> FRAC_BITS;
  assign ovf_mul = (shr[PW-1:CW-1] != {(PW-CW+1){shr[CW-1]}});
  assign trunc   = ovf_mul ? (shr[PW-1] ? SAT_MIN : SAT_MAX) : shr[CW-1:0];
  assign sum     = {trunc[CW-1], trunc} + {offset_i[CW-1], offset_i};
  assign grid_d  = (sum[CW] != sum[CW-1]) ? (sum[CW] ? SAT_MIN : SAT_MAX) : sum[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      grid_q <= grid_d;
    end
  end

  assign grid_o = grid_q;

endmodule

>>> hdl/vna_mod_pipe.sv
// ----------------------------------------------------------------------------
// vna_mod_pipe
// Pipelined restoring remainder, DIV_STEP numerator bits per stage, with tag.
// ----------------------------------------------------------------------------
module vna_mod_pipe #(
  parameter int unsigned NUM_W = 15,
  parameter int unsigned RES_W = 11,
  parameter int unsigned TAG_W = 2
) (
  input  logic             clk_i,
  input  logic [(NUM_W+vna_pkg::DIV_STEP-1)/vna_pkg::DIV_STEP-1:0] ld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [RES_W-1:0] res_i,
  output logic [RES_W-1:0] rem_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned STEP  = vna_pkg::DIV_STEP;
  localparam int unsigned N_DIV = (NUM_W + STEP - 1) / STEP;
  localparam int unsigned PAD_W = N_DIV * STEP;

  logic [PAD_W-1:0] num_q [N_DIV-1];
  logic [RES_W-1:0] rem_q [N_DIV];
  logic [TAG_W-1:0] tag_q [N_DIV];

  function automatic logic [RES_W-1:0] div_steps(
    input logic [RES_W-1:0] rem,
    input logic [STEP-1:0]  bits,
    input logic [RES_W-1:0] res
  );
    logic [RES_W:0] acc;
    acc = {1'b0, rem};
    for (int b = STEP - 1; b >= 0; b--) begin
      acc = {acc[RES_W-1:0], bits[b]};
      if (acc >= {1'b0, res}) begin
        acc = acc - {1'b0, res};
      end
    end
    return acc[RES_W-1:0];
  endfunction

  for (genvar j = 0; j < N_DIV; j++) begin : g_stage
    logic [PAD_W-1:0] num_in;
    logic [RES_W-1:0] rem_in;
    logic [TAG_W-1:0] tag_in;

    if (j == 0) begin : g_first
      assign num_in = PAD_W'(num_i);
      assign rem_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign num_in = num_q[j-1];
      assign rem_in = rem_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        rem_q[j] <= div_steps(rem_in, num_in[PAD_W-1-j*STEP -: STEP], res_i);
        tag_q[j] <= tag_in;
      end
    end

    if (j < N_DIV - 1) begin : g_num
      always_ff @(posedge clk_i) begin
        if (ld_i[j]) begin
          num_q[j] <= num_in;
        end
      end
    end
  end

  assign rem_o = rem_q[N_DIV-1];
  assign tag_o = tag_q[N_DIV-1];

endmodule

>>> hdl/voxel_nearest_address_top.sv
// ----------------------------------------------------------------------------
// voxel_nearest_address_top
// Nearest-voxel linear address of a fixed-point 3D point in a periodic x/y,
// bounded z grid, with APB-style register port.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------
//   in      | sink      | in_valid_i / in_stall_o   | point_x_i/_y_i/_z_i
//   out     | source    | out_valid_o / out_stall_i | voxel_index_o, in_range_o
//   cfg     | sink      | psel, penable, pwrite     | paddr, pwdata, prdata
//
// one word per cycle sustained while out_stall_i is low; depth is set by the
// remainder pipeline for the x/y wrap, which is sized from FRAC_BITS
// rst_ni clears valid bits and loads the register reset values; no clearing pass
// out_stall_i holds the output word; upstream stages keep filling bubbles
// and in_stall_o rises only when every stage holds a word
// ----------------------------------------------------------------------------
module voxel_nearest_address_top #(
  parameter int unsigned MAX_RES   = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vna_pkg::COORD_W-1:0]   point_x_i,
  input  logic [vna_pkg::COORD_W-1:0]   point_y_i,
  input  logic [vna_pkg::COORD_W-1:0]   point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vna_pkg::IDX_W-1:0]     voxel_index_o,
  output logic                          in_range_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vna_pkg::APB_AW-1:0]    paddr,
  input  logic [vna_pkg::APB_DW-1:0]    pwdata,
  output logic [vna_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CW      = vna_pkg::COORD_W;
  localparam int unsigned FW      = vna_pkg::RES_FLD_W;
  localparam int unsigned RES_W   = $clog2(MAX_RES + 1);
  localparam int unsigned NUM_W   = CW - FRAC_BITS - 1;
  localparam int unsigned N_DIV   = (NUM_W + vna_pkg::DIV_STEP - 1) / vna_pkg::DIV_STEP;
  localparam int unsigned N_STG   = N_DIV + 5;
  localparam int unsigned ST_DIV0 = 2;
  localparam int unsigned ST_FIN  = N_DIV + 2;
  localparam int unsigned ST_MUL  = N_DIV + 3;
  localparam int unsigned ST_OUT  = N_DIV + 4;
  localparam int unsigned CMP_W   = (NUM_W > RES_W) ? NUM_W : RES_W;
  localparam int unsigned TAG_X_W = 2;
  localparam int unsigned TAG_Y_W = 3 + RES_W;
  localparam int unsigned T_W     = 2 * RES_W + 1;
  localparam int unsigned P_RAW_W = T_W + RES_W + 1;
  localparam int unsigned P_W     = (P_RAW_W > vna_pkg::IDX_W) ? P_RAW_W : vna_pkg::IDX_W;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]              scale_x_q, scale_y_q, scale_z_q;
  logic [CW-1:0]              offset_x_q, offset_y_q, offset_z_q;
  logic [vna_pkg::GRID_W-1:0] grid_res_q;
  logic                       cfg_wr;
  vna_pkg::reg_idx_e          cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = vna_pkg::reg_idx_e'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= vna_pkg::SCALE_RST;
      scale_y_q  <= vna_pkg::SCALE_RST;
      scale_z_q  <= vna_pkg::SCALE_RST;
      offset_x_q <= vna_pkg::OFFSET_RST;
      offset_y_q <= vna_pkg::OFFSET_RST;
      offset_z_q <= vna_pkg::OFFSET_RST;
      grid_res_q <= vna_pkg::GRID_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vna_pkg::REG_SCALE_X:  scale_x_q  <= pwdata[CW-1:0];
        vna_pkg::REG_SCALE_Y:  scale_y_q  <= pwdata[CW-1:0];
        vna_pkg::REG_SCALE_Z:  scale_z_q  <= pwdata[CW-1:0];
        vna_pkg::REG_OFFSET_X: offset_x_q <= pwdata[CW-1:0];
        vna_pkg::REG_OFFSET_Y: offset_y_q <= pwdata[CW-1:0];
        vna_pkg::REG_OFFSET_Z: offset_z_q <= pwdata[CW-1:0];
        vna_pkg::REG_GRID_RES: grid_res_q <= pwdata[vna_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vna_pkg::REG_SCALE_X:  prdata = {32'h0, scale_x_q};
      vna_pkg::REG_SCALE_Y:  prdata = {32'h0, scale_y_q};
      vna_pkg::REG_SCALE_Z:  prdata = {32'h0, scale_z_q};
      vna_pkg::REG_OFFSET_X: prdata = {32'h0, offset_x_q};
      vna_pkg::REG_OFFSET_Y: prdata = {32'h0, offset_y_q};
      vna_pkg::REG_OFFSET_Z: prdata = {32'h0, offset_z_q};
      vna_pkg::REG_GRID_RES: prdata = vna_pkg::APB_DW'(grid_res_q);
      default:               prdata = '0;
    endcase
  end

  function automatic logic [RES_W-1:0] clamp_res(input logic [FW-1:0] fld);
    logic [FW-1:0] r;
    r = fld;
    if (r < FW'(vna_pkg::MIN_RES)) begin
      r = FW'(vna_pkg::MIN_RES);
    end
    if (r > FW'(MAX_RES)) begin
      r = FW'(MAX_RES);
    end
    return r[RES_W-1:0];
  endfunction

  logic [RES_W-1:0] res_x, res_y, res_z;

  assign res_x = clamp_res(grid_res_q[vna_pkg::RES_X_LSB +: FW]);
  assign res_y = clamp_res(grid_res_q[vna_pkg::RES_Y_LSB +: FW]);
  assign res_z = clamp_res(grid_res_q[vna_pkg::RES_Z_LSB +: FW]);

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic [N_STG-1:0] ld, valid;

  vna_pipe_ctrl #(
    .N_STG (N_STG)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .ld_o        (ld),
    .valid_o     (valid)
  );

  assign out_valid_o = valid[ST_OUT];

  // --------------------------------------------------------------------------
  // grid mapping, two stages per axis
  // --------------------------------------------------------------------------
  logic [CW-1:0] grid_x, grid_y, grid_z;

  vna_grid_map #(.FRAC_BITS(FRAC_BITS)) u_map_x (
    .clk_i (clk_i), .ld_i (ld[1:0]), .point_i (point_x_i),
    .scale_i (scale_x_q), .offset_i (offset_x_q), .grid_o (grid_x)
  );

  vna_grid_map #(.FRAC_BITS(FRAC_BITS)) u_map_y (
    .clk_i (clk_i), .ld_i (ld[1:0]), .point_i (point_y_i),
    .scale_i (scale_y_q), .offset_i (offset_y_q), .grid_o (grid_y)
  );

  vna_grid_map #(.FRAC_BITS(FRAC_BITS)) u_map_z (
    .clk_i (clk_i), .ld_i (ld[1:0]), .point_i (point_z_i),
    .scale_i (scale_z_q), .offset_i (offset_z_q), .grid_o (grid_z)
  );

  // --------------------------------------------------------------------------
  // wrap remainder for x and y; z range check rides in the y tag
  // --------------------------------------------------------------------------
  // negative floor -(m+1) wraps to res-1-(m mod res), m taken from ~bits
  logic [NUM_W-1:0]   num_x, num_y;
  logic [CMP_W-1:0]   z_mag, rz_m1;
  logic               z_ok;
  logic [RES_W-1:0]   iz_pre;
  logic [TAG_X_W-1:0] tag_x_in, tag_x_out;
  logic [TAG_Y_W-1:0] tag_y_in, tag_y_out;
  logic [RES_W-1:0]   rem_x, rem_y;

  assign num_x = grid_x[CW-1] ? ~grid_x[CW-2:FRAC_BITS] : grid_x[CW-2:FRAC_BITS];
  assign num_y = grid_y[CW-1] ? ~grid_y[CW-2:FRAC_BITS] : grid_y[CW-2:FRAC_BITS];

  assign z_mag  = CMP_W'(grid_z[CW-2:FRAC_BITS]);
  assign rz_m1  = CMP_W'(res_z) - CMP_W'(1);
  assign z_ok   = ~grid_z[CW-1] & (z_mag < rz_m1);
  assign iz_pre = z_mag[RES_W-1:0] + RES_W'(grid_z[FRAC_BITS-1]);

  assign tag_x_in = {grid_x[CW-1], grid_x[FRAC_BITS-1]};
  assign tag_y_in = {grid_y[CW-1], grid_y[FRAC_BITS-1], z_ok, iz_pre};

  vna_mod_pipe #(
    .NUM_W (NUM_W), .RES_W (RES_W), .TAG_W (TAG_X_W)
  ) u_mod_x (
    .clk_i (clk_i), .ld_i (ld[ST_FIN-1:ST_DIV0]), .num_i (num_x),
    .tag_i (tag_x_in), .res_i (res_x), .rem_o (rem_x), .tag_o (tag_x_out)
  );

  vna_mod_pipe #(
    .NUM_W (NUM_W), .RES_W (RES_W), .TAG_W (TAG_Y_W)
  ) u_mod_y (
    .clk_i (clk_i), .ld_i (ld[ST_FIN-1:ST_DIV0]), .num_i (num_y),
    .tag_i (tag_y_in), .res_i (res_y), .rem_o (rem_y), .tag_o (tag_y_out)
  );

  // --------------------------------------------------------------------------
  // wrap fix-up and nearest-cell step
  // --------------------------------------------------------------------------
  function automatic logic [RES_W-1:0] wrap_cell(
    input logic [RES_W-1:0] rem,
    input logic [RES_W-1:0] res,
    input logic             neg,
    input logic             up
  );
    logic [RES_W-1:0] c;
    c = neg ? (res - RES_W'(1) - rem) : rem;
    if (up) begin
      c = (c == res - RES_W'(1)) ? '0 : c + RES_W'(1);
    end
    return c;
  endfunction

  logic [RES_W-1:0] ix_q, iy_q, iz_q;
  logic             inr_f_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_FIN]) begin
      ix_q    <= wrap_cell(rem_x, res_x, tag_x_out[1], tag_x_out[0]);
      iy_q    <= wrap_cell(rem_y, res_y, tag_y_out[RES_W+2], tag_y_out[RES_W+1]);
      inr_f_q <= tag_y_out[RES_W];
      iz_q    <= tag_y_out[RES_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // linear index, one multiply per stage
  // --------------------------------------------------------------------------
  logic [T_W-1:0]   t_d, t_q;
  logic [RES_W-1:0] ix_m_q;
  logic             inr_m_q;
  logic [P_W-1:0]   idx_full;
  logic [vna_pkg::IDX_W-1:0] voxel_index_d, voxel_index_q;
  logic             in_range_q;

  assign t_d = T_W'(iz_q) * T_W'(res_y) + T_W'(iy_q);

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL]) begin
      t_q     <= t_d;
      ix_m_q  <= ix_q;
      inr_m_q <= inr_f_q;
    end
  end

  assign idx_full      = P_W'(t_q) * P_W'(res_x) + P_W'(ix_m_q);
  assign voxel_index_d = inr_m_q ? idx_full[vna_pkg::IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (ld[ST_OUT]) begin
      voxel_index_q <= voxel_index_d;
      in_range_q    <= inr_m_q;
    end
  end

  assign voxel_index_o = voxel_index_q;
  assign in_range_o    = in_range_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (voxel_index_o == '0))
    else $error("out-of-range word with nonzero index");

  a_rem_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[ST_FIN-1] |-> (rem_x < res_x))
    else $error("x remainder not below resolution");

  a_rem_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[ST_FIN-1] |-> (rem_y < res_y))
    else $error("y remainder not below resolution");

  a_iz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[ST_FIN] && inr_f_q) |-> (iz_q < res_z))
    else $error("z cell outside grid");

endmodule
